>>> rtl/hnht_pkg.sv
package hnht_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned WAYS_DEF  = 4;
  localparam int unsigned NODE_W    = 8;
  // Every key value, so the slot table covers all of them
  localparam int unsigned NODE_CNT  = 1 << NODE_W;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_SET    = 1'b1
  } opcode_e;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FULL = 1'b1
  } status_e;

  // One way of a slot row
  typedef struct packed {
    logic  valid;
    node_t dest;
    node_t nh;
  } entry_t;

  // Summary of the way compare for one slot row
  typedef struct packed {
    logic  hit;
    logic  has_free;
    node_t hit_nh;
  } match_t;

endpackage

>>> rtl/hnht_match.sv
module hnht_match #(
  parameter int unsigned WAYS = hnht_pkg::WAYS_DEF
) (
  input  hnht_pkg::entry_t [WAYS-1:0] row_i,
  input  hnht_pkg::node_t             dest_i,
  output hnht_pkg::match_t            match_o,
  output logic [WAYS-1:0]             hit_oh_o,
  output logic [WAYS-1:0]             free_oh_o
);

  // Walk from the top way down so the lowest matching way wins
  always_comb begin
    match_o   = '0;
    hit_oh_o  = '0;
    free_oh_o = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_i[w].valid) begin
        if (row_i[w].dest == dest_i) begin
          match_o.hit    = 1'b1;
          match_o.hit_nh = row_i[w].nh;
          hit_oh_o       = WAYS'(1) << w;
        end
      end else begin
        match_o.has_free = 1'b1;
        free_oh_o        = WAYS'(1) << w;
      end
    end
  end

endmodule

>>> rtl/hashed_next_hop_table.sv
// Next-hop routing table, kept as a set-associative hash of SLOTS rows with
// WAYS ways each. The slot is the destination node modulo SLOTS.
//
// Command channel: a beat (opcode_i, dest_node_i, next_hop_in_i) is taken at
// a rising edge with start high and busy low. A lookup returns found_o and
// the stored next hop; a set rewrites an existing entry or fills the lowest
// free way of the slot, and reports status_o = full when no way is free.
//
// Result channel: done_o marks one result beat for exactly one cycle. Once a
// beat is taken its row is read into rdata_q, and the work state then loads
// the result registers from the way compare; the receiver cannot stall them.
//
// Each beat reads its slot row, then compares the ways and writes the row
// back; no new beat is taken until the last is through. The slot row sits in
// a single-port synchronous memory. busy stays high over the write-back, so
// no two beats touch a row at once and no forwarding path is needed.
//
// Reset: a clearing pass walks the memory one row per cycle over all SLOTS
// rows, with busy held high; the table is empty once busy falls.
module hashed_next_hop_table #(
  parameter int unsigned SLOTS = hnht_pkg::SLOTS_DEF,
  parameter int unsigned WAYS  = hnht_pkg::WAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode_i,
  input  hnht_pkg::node_t       dest_node_i,
  input  hnht_pkg::node_t       next_hop_in_i,
  output logic                  done_o,
  output logic                  found_o,
  output hnht_pkg::node_t       next_hop_o,
  output logic                  status_o
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WORK
  } state_e;

  state_e state_q;
  logic [SlotW-1:0] clr_q;

  // Slot of every possible key, worked out at elaboration
  logic [SlotW-1:0] slot_tab [hnht_pkg::NODE_CNT];
  for (genvar k = 0; k < hnht_pkg::NODE_CNT; k++) begin : g_slot
    assign slot_tab[k] = SlotW'(k % SLOTS);
  end

  logic             accept;
  logic [SlotW-1:0] slot;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign slot   = slot_tab[dest_node_i];

  // Held copy of the beat in flight
  logic             op_q;
  hnht_pkg::node_t  dest_q;
  hnht_pkg::node_t  nh_q;
  logic [SlotW-1:0] slot_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      dest_q <= dest_node_i;
      nh_q   <= next_hop_in_i;
      slot_q <= slot;
    end
  end

  // Row memory and its registered read port
  hnht_pkg::entry_t [WAYS-1:0] row_mem [SLOTS];
  hnht_pkg::entry_t [WAYS-1:0] rdata_q;
  hnht_pkg::entry_t [WAYS-1:0] row_wr;
  logic                        wr_en;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      row_mem[clr_q] <= '0;
    end else if (state_q == S_WORK && wr_en) begin
      row_mem[slot_q] <= row_wr;
    end
    if (accept) begin
      rdata_q <= row_mem[slot];
    end
  end

  hnht_pkg::match_t match;
  logic [WAYS-1:0]  hit_oh;
  logic [WAYS-1:0]  free_oh;

  hnht_match #(
    .WAYS (WAYS)
  ) u_match (
    .row_i     (rdata_q),
    .dest_i    (dest_q),
    .match_o   (match),
    .hit_oh_o  (hit_oh),
    .free_oh_o (free_oh)
  );

  logic is_set;
  assign is_set = (op_q == hnht_pkg::OP_SET);

  // Modify the row: rewrite the hit way, or claim the lowest free way
  always_comb begin
    row_wr = rdata_q;
    for (int w = 0; w < WAYS; w++) begin
      if (is_set && match.hit && hit_oh[w]) begin
        row_wr[w].nh = nh_q;
      end else if (is_set && !match.hit && free_oh[w]) begin
        row_wr[w].valid = 1'b1;
        row_wr[w].dest  = dest_q;
        row_wr[w].nh    = nh_q;
      end
    end
  end

  assign wr_en = is_set && (match.hit || match.has_free);

  // Sequencer: clear pass, then one beat at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      done_o     <= 1'b0;
      found_o    <= 1'b0;
      next_hop_o <= '0;
      status_o   <= hnht_pkg::ST_OK;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SlotW'(1);
          if (clr_q == SlotW'(SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_WORK;
          end
        end
        S_WORK: begin
          // Drive the result beat; a set never reports a next hop
          done_o     <= 1'b1;
          found_o    <= match.hit;
          next_hop_o <= (!is_set && match.hit) ? match.hit_nh : '0;
          status_o   <= (is_set && !match.hit && !match.has_free) ?
                        hnht_pkg::ST_FULL : hnht_pkg::ST_OK;
          state_q    <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/hnht_checker.sv
module hnht_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            opcode_i,
  input logic            done_o,
  input logic            found_o,
  input hnht_pkg::node_t next_hop_o,
  input logic            status_o
);

  logic accept;
  assign accept = start && !busy;

  // Each taken beat is followed by its result beat
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("result beat missing after command beat");

  // No result without a command beat in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a command in flight");

  // A lookup never reports a full slot
  a_lookup_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == hnht_pkg::OP_LOOKUP) |-> ##2 (status_o == hnht_pkg::ST_OK))
    else $error("lookup reported full slot");

  // A full slot only turns away a key that is absent
  a_full_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == hnht_pkg::ST_FULL) |-> !found_o)
    else $error("full slot reported with a hit");

  // A miss carries no next hop
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (next_hop_o == '0))
    else $error("next hop on a miss");

endmodule

bind hashed_next_hop_table hnht_checker u_hnht_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .opcode_i   (opcode_i),
  .done_o     (done_o),
  .found_o    (found_o),
  .next_hop_o (next_hop_o),
  .status_o   (status_o)
);
